[rtl/core/stereo_comb_allpass_reverb_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the reverb unit
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef STEREO_COMB_ALLPASS_REVERB_UNIT_MACROS_SVH
`define STEREO_COMB_ALLPASS_REVERB_UNIT_MACROS_SVH

// implication checked on every clock edge outside reset
`define SCAR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define SCAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/scar_pkg.sv]
// ----------------------------------------------------------------------------
// Reverb package
// Types and fixed constants shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package scar_pkg;

    localparam int BYPASS_LIMIT = 66;
    localparam int GAIN_IN_Q16  = 786;
    localparam int AP_GAIN_Q16  = 32768;

    typedef enum logic [0:0] {
        REQ_AUDIO = 1'b0,
        REQ_CLEAR = 1'b1
    } req_t;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE     = 4'd0,
        OP_SETUP    = 4'd1,
        OP_COMB_RD  = 4'd2,
        OP_COMB_LP  = 4'd3,
        OP_COMB_WR  = 4'd4,
        OP_AP_RD    = 4'd5,
        OP_AP_WR    = 4'd6,
        OP_MIX_A    = 4'd7,
        OP_MIX_B    = 4'd8,
        OP_CLEAR    = 4'd9,
        OP_CH_START = 4'd10
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       ch;
        logic [4:0] idx;
    } scar_cmd_t;

    typedef struct packed {
        logic clear_done;
    } scar_stat_t;

    // scaled line length, half up
    function automatic int scale_len(input int base, input int rate);
        return int'((longint'(base) * rate * 2 + 44100) / 88200);
    endfunction

    function automatic int comb_base(input int k);
        case (k % 8)
            0: return 1116;
            1: return 1188;
            2: return 1277;
            3: return 1356;
            4: return 1422;
            5: return 1491;
            6: return 1557;
            default: return 1617;
        endcase
    endfunction

    function automatic int ap_base(input int k);
        case (k % 4)
            0: return 225;
            1: return 341;
            2: return 441;
            default: return 556;
        endcase
    endfunction

endpackage

[rtl/core/scar_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module scar_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end

endmodule

[rtl/core/scar_ctrl.sv]
// ----------------------------------------------------------------------------
// Reverb controller
// Sequences combs, allpasses and the output mix through the datapath.
// ----------------------------------------------------------------------------
module scar_ctrl
    import scar_pkg::*;
#(
    parameter int COMB_COUNT    = 8,
    parameter int ALLPASS_COUNT = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic       in_clear,
    input  logic       bypass,
    input  logic       stereo,
    input  logic       out_busy,
    input  scar_stat_t stat,
    output scar_cmd_t  cmd,
    output logic       idle,
    output logic       emit
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_SETUP = 11'b00000000010,
        S_CRD   = 11'b00000000100,
        S_CLP   = 11'b00000001000,
        S_CWR   = 11'b00000010000,
        S_ARD   = 11'b00000100000,
        S_AWR   = 11'b00001000000,
        S_MIXA  = 11'b00010000000,
        S_MIXB  = 11'b00100000000,
        S_EMIT  = 11'b01000000000,
        S_CLR   = 11'b10000000000
    } state_t;

    state_t     state_reg, state_next;
    logic       ch_reg, ch_next;
    logic [4:0] idx_reg, idx_next;

    // line memories are swept to zero right after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            ch_reg    <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            idx_reg   <= idx_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        idx_next   = idx_reg;
        cmd.op     = OP_NONE;
        cmd.ch     = ch_reg;
        cmd.idx    = idx_reg;
        emit       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    ch_next  = 1'b0;
                    idx_next = '0;
                    if (in_clear)
                        state_next = S_CLR;
                    else if (bypass)
                        state_next = S_EMIT;
                    else
                        state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.op     = OP_SETUP;
                state_next = S_CRD;
            end
            S_CRD:
            begin
                cmd.op     = (idx_reg == 5'd0) ? OP_CH_START : OP_COMB_RD;
                state_next = S_CLP;
            end
            S_CLP:
            begin
                cmd.op     = OP_COMB_LP;
                state_next = S_CWR;
            end
            S_CWR:
            begin
                cmd.op = OP_COMB_WR;
                if (idx_reg == 5'(COMB_COUNT - 1))
                begin
                    idx_next   = '0;
                    state_next = S_ARD;
                end
                else
                begin
                    idx_next   = idx_reg + 5'd1;
                    state_next = S_CRD;
                end
            end
            S_ARD:
            begin
                cmd.op     = OP_AP_RD;
                state_next = S_AWR;
            end
            S_AWR:
            begin
                cmd.op = OP_AP_WR;
                if (idx_reg == 5'(ALLPASS_COUNT - 1))
                begin
                    idx_next   = '0;
                    state_next = S_MIXA;
                end
                else
                begin
                    idx_next   = idx_reg + 5'd1;
                    state_next = S_ARD;
                end
            end
            S_MIXA:
            begin
                cmd.op     = OP_MIX_A;
                state_next = S_MIXB;
            end
            S_MIXB:
            begin
                cmd.op = OP_MIX_B;
                if (!ch_reg && stereo)
                begin
                    ch_next    = 1'b1;
                    state_next = S_CRD;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_busy)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CLR:
            begin
                cmd.op = OP_CLEAR;
                if (stat.clear_done)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign idle = (state_reg == S_IDLE);

endmodule

[rtl/core/scar_dp.sv]
// ----------------------------------------------------------------------------
// Reverb datapath
// Line memories, lowpass states, positions and the Q16 multiply-add unit.
// ----------------------------------------------------------------------------
module scar_dp
    import scar_pkg::*;
#(
    parameter int AUDIO_FS      = 48000,
    parameter int COMB_COUNT    = 8,
    parameter int ALLPASS_COUNT = 4,
    parameter int DATA_WIDTH    = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  scar_cmd_t          cmd,
    input  logic               load,
    input  logic signed [15:0] sample_left,
    input  logic signed [15:0] sample_right,
    input  logic [16:0]        mix,
    input  logic               stereo,
    output scar_stat_t         stat,
    output logic signed [15:0] res_left,
    output logic signed [15:0] res_right
);

    localparam int FRAC    = DATA_WIDTH - 5;
    localparam int SPREAD  = scale_len(23, AUDIO_FS);
    localparam int CMAX    = scale_len(1617, AUDIO_FS) + SPREAD;
    localparam int AMAX    = scale_len(556, AUDIO_FS) + SPREAD;
    localparam int NC      = 2 * COMB_COUNT;
    localparam int NA      = 2 * ALLPASS_COUNT;
    localparam int CDEPTH  = NC * CMAX;
    localparam int ADEPTH  = NA * AMAX;
    localparam int CAW     = $clog2(CDEPTH);
    localparam int AAW     = $clog2(ADEPTH);
    localparam int PW      = $clog2(CMAX + 1);
    localparam int APW     = $clog2(AMAX + 1);
    localparam int CIW     = $clog2(NC);
    localparam int AIW     = (NA > 1) ? $clog2(NA) : 1;
    localparam int CLRW    = (CAW > AAW) ? CAW : AAW;
    localparam int PWID    = DATA_WIDTH + 18;

    typedef logic signed [DATA_WIDTH-1:0] data_t;

    localparam data_t DMAX  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam data_t DMIN  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam data_t ONE_Q = data_t'(1) <<< FRAC;

    function automatic data_t sat(input logic signed [PWID-1:0] v);
        if (v > PWID'(DMAX))
            return DMAX;
        if (v < PWID'(DMIN))
            return DMIN;
        return v[DATA_WIDTH-1:0];
    endfunction

    // round half up by Q16 coefficient, saturate
    function automatic data_t mulq(input data_t x, input logic [16:0] c);
        logic signed [PWID-1:0] p;
        p = PWID'(x) * $signed({1'b0, c}) + PWID'(32768);
        return sat(p >>> 16);
    endfunction

    function automatic data_t add_s(input data_t a, input data_t b);
        return sat(PWID'(a) + PWID'(b));
    endfunction

    function automatic logic [PW-1:0] clen(input int i);
        return PW'(scale_len(comb_base(i % COMB_COUNT), AUDIO_FS)
                   + ((i >= COMB_COUNT) ? SPREAD : 0));
    endfunction

    function automatic logic [APW-1:0] alen(input int i);
        return APW'(scale_len(ap_base(i % ALLPASS_COUNT), AUDIO_FS)
                    + ((i >= ALLPASS_COUNT) ? SPREAD : 0));
    endfunction

    // constant line length tables
    logic [PW-1:0]  clen_tab [NC];
    logic [APW-1:0] alen_tab [NA];

    for (genvar g = 0; g < NC; g++)
    begin : g_clen
        assign clen_tab[g] = clen(g);
    end

    for (genvar g = 0; g < NA; g++)
    begin : g_alen
        assign alen_tab[g] = alen(g);
    end

    // per-line state
    logic [PW-1:0]  cpos_reg [NC];
    logic [APW-1:0] apos_reg [NA];
    data_t          lp_reg   [NC];

    data_t          in_reg, inl_reg, inr_reg, acc_reg, lp_tmp_reg, fa_reg;
    logic [16:0]    fb_reg, d1_reg, d2_reg, m_reg;
    logic signed [15:0] sl_reg, sr_reg, res_l_reg, res_r_reg;
    logic [CLRW:0]  clr_reg;

    // line index selection
    logic [CIW-1:0] ci;
    logic [AIW-1:0] ai;
    logic [PW-1:0]  cpos_cur, cpos_inc;
    logic [APW-1:0] apos_cur, apos_inc;

    always_comb
    begin
        ci = CIW'(cmd.ch) * CIW'(COMB_COUNT) + CIW'(cmd.idx);
        ai = AIW'(cmd.ch) * AIW'(ALLPASS_COUNT) + AIW'(cmd.idx);
        cpos_cur = (cpos_reg[ci] >= clen_tab[ci]) ? '0 : cpos_reg[ci];
        apos_cur = (apos_reg[ai] >= alen_tab[ai]) ? '0 : apos_reg[ai];
        cpos_inc = (cpos_cur + PW'(1) >= clen_tab[ci]) ? '0 : cpos_cur + PW'(1);
        apos_inc = (apos_cur + APW'(1) >= alen_tab[ai]) ? '0 : apos_cur + APW'(1);
    end

    // memory ports
    logic            c_we, a_we;
    logic [CAW-1:0]  c_addr;
    logic [AAW-1:0]  a_addr;
    data_t           c_wdata, a_wdata, c_rdata, a_rdata;
    logic            clearing;

    assign clearing = (cmd.op == OP_CLEAR);

    always_comb
    begin
        c_addr  = CAW'(CAW'(ci) * CAW'(CMAX) + CAW'(cpos_cur));
        a_addr  = AAW'(AAW'(ai) * AAW'(AMAX) + AAW'(apos_cur));
        c_we    = (cmd.op == OP_COMB_WR);
        a_we    = (cmd.op == OP_AP_WR);
        c_wdata = add_s(in_reg, mulq(lp_tmp_reg, fb_reg));
        a_wdata = add_s(acc_reg, mulq(a_rdata, 17'(AP_GAIN_Q16)));
        if (clearing)
        begin
            c_addr  = CAW'(clr_reg);
            a_addr  = AAW'(clr_reg);
            c_we    = (clr_reg < (CLRW+1)'(CDEPTH));
            a_we    = (clr_reg < (CLRW+1)'(ADEPTH));
            c_wdata = '0;
            a_wdata = '0;
        end
    end

    scar_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CDEPTH)) u_comb_ram (
        .clk   (clk),
        .we    (c_we),
        .addr  (c_addr),
        .wdata (c_wdata),
        .rdata (c_rdata)
    );

    scar_ram #(.WIDTH(DATA_WIDTH), .DEPTH(ADEPTH)) u_ap_ram (
        .clk   (clk),
        .we    (a_we),
        .addr  (a_addr),
        .wdata (a_wdata),
        .rdata (a_rdata)
    );

    assign stat.clear_done = clearing &&
        (clr_reg == (CLRW+1)'((CDEPTH > ADEPTH) ? CDEPTH : ADEPTH));

    // final mix to 16-bit output, truncated toward zero
    function automatic logic signed [15:0] to_out(input data_t f);
        logic signed [DATA_WIDTH+15:0] p;
        data_t c;
        logic signed [DATA_WIDTH+15:0] q;
        c = f;
        if (f > ONE_Q)
            c = ONE_Q;
        if (f < -ONE_Q)
            c = -ONE_Q;
        p = (DATA_WIDTH+16)'(c) * (DATA_WIDTH+16)'(32767);
        if (p >= 0)
            q = p >>> FRAC;
        else
            q = -((-p) >>> FRAC);
        return q[15:0];
    endfunction

    logic [16:0] m_cl;
    assign m_cl = (mix > 17'd65536) ? 17'd65536 : mix;

    // per-op register updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NC; i++)
            begin
                cpos_reg[i] <= '0;
                lp_reg[i]   <= '0;
            end
            for (int i = 0; i < NA; i++)
                apos_reg[i] <= '0;
            clr_reg <= '0;
        end
        else
        begin
            if (clearing)
            begin
                clr_reg <= clr_reg + 1'b1;
                for (int i = 0; i < NC; i++)
                    lp_reg[i] <= '0;
                if (stat.clear_done)
                    clr_reg <= '0;
            end
            if (cmd.op == OP_COMB_WR)
            begin
                lp_reg[ci]   <= lp_tmp_reg;
                cpos_reg[ci] <= cpos_inc;
            end
            if (cmd.op == OP_AP_WR)
                apos_reg[ai] <= apos_inc;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sl_reg <= sample_left;
            sr_reg <= sample_right;
            m_reg  <= m_cl;
            res_l_reg <= sample_left;
            res_r_reg <= stereo ? sample_right : 16'sd0;
        end
        case (cmd.op)
            OP_SETUP:
            begin
                fb_reg  <= 17'(58720 + ((5138 * 32'(m_reg) + 32768) >> 16));
                d1_reg  <= 17'(7864 + ((14418 * 32'(m_reg) + 32768) >> 16));
                d2_reg  <= 17'(65536 - (7864 + ((14418 * 32'(m_reg) + 32768) >> 16)));
                inl_reg <= data_t'(sl_reg) <<< (FRAC - 15);
                inr_reg <= data_t'(sr_reg) <<< (FRAC - 15);
                if (stereo)
                    in_reg <= mulq(add_s(data_t'(sl_reg) <<< (FRAC - 15),
                                         data_t'(sr_reg) <<< (FRAC - 15)),
                                   17'(GAIN_IN_Q16));
                else
                    in_reg <= mulq(data_t'(sl_reg) <<< (FRAC - 15), 17'(GAIN_IN_Q16));
                res_r_reg <= '0;
            end
            OP_CH_START:
                acc_reg <= '0;
            OP_COMB_LP:
            begin
                lp_tmp_reg <= add_s(mulq(c_rdata, d2_reg), mulq(lp_reg[ci], d1_reg));
                acc_reg    <= add_s(acc_reg, c_rdata);
            end
            // difference taken at full width so a full-scale negative sum saturates
            OP_AP_WR:
                acc_reg <= sat(PWID'(a_rdata) - PWID'(acc_reg));
            OP_MIX_A:
                fa_reg <= mulq(cmd.ch ? inr_reg : inl_reg, 17'(17'd65536 - m_reg));
            OP_MIX_B:
            begin
                if (cmd.ch)
                    res_r_reg <= to_out(add_s(fa_reg, mulq(acc_reg, m_reg)));
                else
                    res_l_reg <= to_out(add_s(fa_reg, mulq(acc_reg, m_reg)));
            end
            default:
            begin
            end
        endcase
    end

    assign res_left  = res_l_reg;
    assign res_right = res_r_reg;

endmodule

[rtl/core/stereo_comb_allpass_reverb_unit.sv]
// ----------------------------------------------------------------------------
// Stereo comb/allpass reverb unit
// Freeverb-style reverb on 16-bit frames with APB configuration.
// ----------------------------------------------------------------------------
// One frame is processed at a time. After reset, and on every clear request,
// both line memories are swept to zero one entry per cycle; the sweep covers
// the depth of the larger line memory (2*COMB_COUNT times the longest comb
// line at the defaults), no input transfer is taken meanwhile and a clear
// returns no result. A stereo frame runs the setup state, then per channel
// the read, lowpass and write states of each comb, the read and write states
// of each allpass and the mix states, then the emit state, which loads the
// output register; the next frame can be taken in the cycle after. A mono
// frame runs one channel, a bypassed frame goes straight to the emit state.
// Each line memory has a single port, visited once per read and once per
// write. A result waiting in the output register holds the controller until it is taken.
module stereo_comb_allpass_reverb_unit
    import scar_pkg::*;
#(
    parameter int AUDIO_FS      = 48000,
    parameter int COMB_COUNT    = 8,
    parameter int ALLPASS_COUNT = 4,
    parameter int DATA_WIDTH    = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // sample_left[15:0], sample_right[31:16]
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // out_left[15:0], out_right[31:16]
);

    localparam logic [2:0] ADDR_WET_MIX = 3'd0;
    localparam logic [2:0] ADDR_STEREO  = 3'd4;

    logic [16:0] wet_mix_reg;
    logic        stereo_reg;

    // configuration registers
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wet_mix_reg <= '0;
            stereo_reg  <= 1'b1;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == ADDR_WET_MIX)
                wet_mix_reg <= pwdata[16:0];
            else if (paddr == ADDR_STEREO)
                stereo_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_WET_MIX: prdata = {15'd0, wet_mix_reg};
            ADDR_STEREO:  prdata = {31'd0, stereo_reg};
            default:      prdata = '0;
        endcase
    end

    // control and datapath
    scar_cmd_t  cmd;
    scar_stat_t stat;
    logic       idle, emit, in_fire, bypass;
    logic signed [15:0] res_l, res_r;
    logic       m_valid_reg;
    logic [31:0] m_data_reg;

    assign s_tready = idle;
    assign in_fire  = s_tvalid && s_tready;
    assign bypass   = (wet_mix_reg < 17'(BYPASS_LIMIT));

    scar_ctrl #(.COMB_COUNT(COMB_COUNT), .ALLPASS_COUNT(ALLPASS_COUNT)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_clear (s_tuser == REQ_CLEAR),
        .bypass   (bypass),
        .stereo   (stereo_reg),
        .out_busy (m_valid_reg && !m_tready),
        .stat     (stat),
        .cmd      (cmd),
        .idle     (idle),
        .emit     (emit)
    );

    scar_dp #(
        .AUDIO_FS(AUDIO_FS), .COMB_COUNT(COMB_COUNT),
        .ALLPASS_COUNT(ALLPASS_COUNT), .DATA_WIDTH(DATA_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .load         (in_fire),
        .sample_left  (s_tdata[15:0]),
        .sample_right (s_tdata[31:16]),
        .mix          (wet_mix_reg),
        .stereo       (stereo_reg),
        .stat         (stat),
        .res_left     (res_l),
        .res_right    (res_r)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (emit)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            m_data_reg <= {res_r, res_l};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

[rtl/core/scar_checker.sv]
// ----------------------------------------------------------------------------
// Reverb port checker
// Watches the top-level ports and is bound to the unit.
// ----------------------------------------------------------------------------
`include "stereo_comb_allpass_reverb_unit_macros.svh"

module scar_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        pready,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a result stays until taken
    `SCAR_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // one frame at a time: no accept right after an accept
    `SCAR_ASSERT_NEXT(a_one_item, clk, rst_n, s_tvalid && s_tready, !s_tready)
    // configuration port never stalls
    `SCAR_ASSERT_IMPL(a_pready, clk, rst_n, 1'b1, pready)

endmodule

bind stereo_comb_allpass_reverb_unit scar_checker u_scar_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
